// ===== rtl/dtrg_pkg.sv =====
// dtrg_pkg: constants, payload structs and the control store of the dag task release gate
// used by dag_task_release_gate; depends on nothing else
package dtrg_pkg;

  // graph and table sizes
  localparam int MAX_TASKS   = 32;
  localparam int MAX_SENSORS = 8;
  localparam int SIDX_W      = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int SCNT_W      = $clog2(MAX_SENSORS + 1);

  // sensor stamp that means no time yet
  localparam logic signed [31:0] STAMP_NONE = -32'sd1;

  // configuration register indexes
  localparam logic [2:0] CFG_OWN_TASK  = 3'd0;
  localparam logic [2:0] CFG_PRIORITY  = 3'd1;
  localparam logic [2:0] CFG_EXEC      = 3'd2;
  localparam logic [2:0] CFG_PERIOD    = 3'd3;
  localparam logic [2:0] CFG_PARENTS   = 3'd4;
  localparam logic [2:0] CFG_SENSORS   = 3'd5;

  // item function codes
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // sequencer step addresses
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_MERGE  = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  // datapath actions
  localparam logic [2:0] ACT_LATCH = 3'd0;
  localparam logic [2:0] ACT_NOP   = 3'd1;
  localparam logic [2:0] ACT_MERGE = 3'd2;
  localparam logic [2:0] ACT_CHECK = 3'd3;
  localparam logic [2:0] ACT_EMIT  = 3'd4;

  // jump conditions
  localparam logic [2:0] CND_ALWAYS = 3'd0;
  localparam logic [2:0] CND_START  = 3'd1;
  localparam logic [2:0] CND_TICK   = 3'd2;
  localparam logic [2:0] CND_READY  = 3'd3;
  localparam logic [2:0] CND_LAST   = 3'd4;

  typedef struct packed {
    logic              func;
    logic [30:0]       now_time;
    logic [4:0]        source_task;
    logic [2:0]        sensor_index;
    logic signed [31:0] sensor_stamp;
    logic              last_element;
  } in_t;

  typedef struct packed {
    logic [4:0]        job_task;
    logic [31:0]       job_number;
    logic [7:0]        job_prio;
    logic [15:0]       job_exec;
    logic [30:0]       release_time;
    logic [2:0]        out_sensor;
    logic signed [31:0] out_stamp;
    logic              end_of_job;
  } out_t;

  // one control word: action, condition, targets when it holds and when not
  typedef struct packed {
    logic [2:0] act;
    logic [2:0] cnd;
    logic [2:0] tgt_true;
    logic [2:0] tgt_false;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [2:0] step);
    ucode_t w;
    case (step)
      ST_IDLE:   w = '{act: ACT_LATCH, cnd: CND_START,  tgt_true: ST_DECODE, tgt_false: ST_IDLE};
      ST_DECODE: w = '{act: ACT_NOP,   cnd: CND_TICK,   tgt_true: ST_CHECK,  tgt_false: ST_MERGE};
      ST_MERGE:  w = '{act: ACT_MERGE, cnd: CND_ALWAYS, tgt_true: ST_IDLE,   tgt_false: ST_IDLE};
      ST_CHECK:  w = '{act: ACT_CHECK, cnd: CND_READY,  tgt_true: ST_EMIT,   tgt_false: ST_IDLE};
      ST_EMIT:   w = '{act: ACT_EMIT,  cnd: CND_LAST,   tgt_true: ST_IDLE,   tgt_false: ST_EMIT};
      default:   w = '{act: ACT_NOP,   cnd: CND_ALWAYS, tgt_true: ST_IDLE,   tgt_false: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dag_task_release_gate.sv =====
// dag_task_release_gate: release gate of one task node in a dag of periodic tasks
// microcoded sequencer over a small datapath; depends on dtrg_pkg
//
// Usage:
// - item channel: item_i is taken at a clock edge where start is high and busy is low.
//   func update merges one sensor stamp and may mark a parent done; func tick tests
//   readiness and, on release, emits one result word per sensor entry in use.
// - result channel: each result word sits on result_o for one cycle with result_valid_o
//   high; the receiver takes it at the end of that cycle and cannot stall the block.
// - config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is
//   always high; write only while busy is low and no result is pending.
// - sequence: an update walks the decode and merge steps; a tick walks decode and check
//   and, on release, one emit step per entry (n sensor entries, up to 8), each emit
//   step reading the sensor table once. busy stays high from acceptance until the
//   sequencer is back in idle. results appear one per cycle starting the cycle after
//   the first emit step.
// - reset: the sensor table goes to -1, parent marks, job count and last release
//   clear, and the registers take their reset values.
module dag_task_release_gate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  dtrg_pkg::in_t      item_i,
  output logic               result_valid_o,
  output dtrg_pkg::out_t     result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import dtrg_pkg::*;

  // configuration registers
  logic [4:0]         own_task_q;
  logic [7:0]         prio_q;
  logic [15:0]        exec_q;
  logic signed [31:0] period_q;
  logic [MAX_TASKS-1:0] parents_q;
  logic [3:0]         sensors_q;

  // block state
  logic [MAX_TASKS-1:0] done_q, done_d;
  logic signed [31:0]   table_q [MAX_SENSORS];
  logic [30:0]          last_rel_q, last_rel_d;
  logic [31:0]          job_cnt_q, job_cnt_d;

  // sequencer and datapath registers
  logic [2:0]        step_q, step_d;
  logic [SIDX_W-1:0] k_q, k_d;
  in_t               item_q;
  out_t              out_q;
  logic              out_vld_q, out_vld_d;

  ucode_t             uw;
  logic               accept;
  logic               cond;
  logic [SCNT_W-1:0]  n_eff;
  logic               is_source;
  logic               triggered;
  logic signed [31:0] diff;
  logic               period_ok;
  logic               ready;
  logic               last_k;
  logic [SIDX_W-1:0]  rd_addr;
  logic signed [31:0] rd_data;
  logic               wr_en;
  logic [SIDX_W-1:0]  wr_addr;
  logic signed [31:0] wr_data;

  assign cfg_ready_o    = 1'b1;
  assign busy           = (step_q != ST_IDLE);
  assign accept         = start && !busy;
  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;
  assign uw             = ucode_rom(step_q);

  // effective sensor count: zero acts as one, clip at the table depth
  always_comb begin
    if (sensors_q == 4'd0) begin
      n_eff = SCNT_W'(1);
    end else if (32'(sensors_q) > MAX_SENSORS) begin
      n_eff = SCNT_W'(MAX_SENSORS);
    end else begin
      n_eff = SCNT_W'(sensors_q);
    end
  end

  // readiness of a tick
  assign is_source = (parents_q == '0);
  assign triggered = is_source || ((done_q & parents_q) == parents_q);
  assign diff      = $signed({1'b0, item_q.now_time}) - $signed({1'b0, last_rel_q});
  always_comb begin
    if (period_q < 0) begin
      period_ok = 1'b0;
    end else if (period_q == 32'sd0) begin
      period_ok = 1'b1;
    end else if (item_q.now_time == 31'd0) begin
      period_ok = is_source;
    end else begin
      period_ok = (diff == period_q);
    end
  end
  assign ready  = triggered && period_ok;
  assign last_k = ((SCNT_W'(k_q) + SCNT_W'(1)) == n_eff);

  // jump condition select
  always_comb begin
    case (uw.cnd)
      CND_ALWAYS: cond = 1'b1;
      CND_START:  cond = accept;
      CND_TICK:   cond = (item_q.func == FUNC_TICK);
      CND_READY:  cond = ready;
      CND_LAST:   cond = last_k;
      default:    cond = 1'b0;
    endcase
  end

  // single sensor table read port
  assign rd_addr = (uw.act == ACT_EMIT) ? k_q : item_q.sensor_index[SIDX_W-1:0];
  assign rd_data = table_q[rd_addr];

  // datapath actions
  always_comb begin
    step_d     = cond ? uw.tgt_true : uw.tgt_false;
    k_d        = k_q;
    done_d     = done_q;
    last_rel_d = last_rel_q;
    job_cnt_d  = job_cnt_q;
    out_vld_d  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = item_q.sensor_index[SIDX_W-1:0];
    wr_data    = item_q.sensor_stamp;
    case (uw.act)
      ACT_LATCH: begin
      end
      ACT_NOP: begin
      end
      ACT_MERGE: begin
        // max merge into an in-range entry, then mark a parent done
        if ((SCNT_W'(item_q.sensor_index) < n_eff) && (item_q.sensor_stamp > rd_data)) begin
          wr_en = 1'b1;
        end
        if (item_q.last_element && parents_q[item_q.source_task]) begin
          done_d[item_q.source_task] = 1'b1;
        end
      end
      ACT_CHECK: begin
        // a releasing source task records its own time, if its own entry is in use
        k_d     = '0;
        wr_addr = own_task_q[SIDX_W-1:0];
        wr_data = $signed({1'b0, item_q.now_time});
        if (ready && is_source && ({1'b0, own_task_q} < 6'(n_eff))) begin
          wr_en = 1'b1;
        end
      end
      ACT_EMIT: begin
        out_vld_d = 1'b1;
        k_d       = k_q + SIDX_W'(1);
        if (last_k) begin
          last_rel_d = item_q.now_time;
          job_cnt_d  = job_cnt_q + 32'd1;
          done_d     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= ST_IDLE;
      k_q        <= '0;
      out_vld_q  <= 1'b0;
      done_q     <= '0;
      last_rel_q <= '0;
      job_cnt_q  <= '0;
      for (int i = 0; i < MAX_SENSORS; i++) begin
        table_q[i] <= STAMP_NONE;
      end
    end else begin
      step_q     <= step_d;
      k_q        <= k_d;
      out_vld_q  <= out_vld_d;
      done_q     <= done_d;
      last_rel_q <= last_rel_d;
      job_cnt_q  <= job_cnt_d;
      if (wr_en) begin
        table_q[wr_addr] <= wr_data;
      end
    end
  end

  // item latch and result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (uw.act == ACT_EMIT) begin
      out_q.job_task     <= own_task_q;
      out_q.job_number   <= job_cnt_q;
      out_q.job_prio     <= prio_q;
      out_q.job_exec     <= exec_q;
      out_q.release_time <= item_q.now_time;
      out_q.out_sensor   <= 3'(k_q);
      out_q.out_stamp    <= rd_data;
      out_q.end_of_job   <= last_k;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_task_q <= '0;
      prio_q     <= '0;
      exec_q     <= '0;
      period_q   <= STAMP_NONE;
      parents_q  <= '0;
      sensors_q  <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_OWN_TASK: own_task_q <= cfg_data_i[4:0];
        CFG_PRIORITY: prio_q     <= cfg_data_i[7:0];
        CFG_EXEC:     exec_q     <= cfg_data_i[15:0];
        CFG_PERIOD:   period_q   <= $signed(cfg_data_i);
        CFG_PARENTS:  parents_q  <= cfg_data_i[MAX_TASKS-1:0];
        CFG_SENSORS:  sensors_q  <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/dag_task_release_gate_checker.sv =====
`timescale 1ns / 100ps
// dag_task_release_gate_checker: predicts the job words of the dag task release gate
// from the item and config words it sees, and compares them with the emitted words
// depends on dtrg_pkg
module dag_task_release_gate_checker
  import dtrg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_start_i,
  input  logic        item_busy_i,
  input  in_t         item_i,
  input  logic        result_valid_i,
  input  out_t        result_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          due_words_o,
  output int          mismatches_o
);

  // register copies
  logic [4:0]         own_id;
  logic [7:0]         prio;
  logic [15:0]        exec_len;
  logic signed [31:0] period;
  logic [31:0]        parents;
  logic [3:0]         sensors;

  // gate state
  logic [31:0]        done_marks;
  logic signed [31:0] stamps [MAX_SENSORS];
  logic [30:0]        last_rel;
  logic [31:0]        job_count;

  out_t               job_words [$];
  out_t               want;
  int                 misses;
  int                 live;
  bit                 fires;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id     = '0;
      prio       = '0;
      exec_len   = '0;
      period     = -32'sd1;
      parents    = '0;
      sensors    = 4'd1;
      done_marks = '0;
      for (int k = 0; k < MAX_SENSORS; k++) stamps[k] = STAMP_NONE;
      last_rel   = '0;
      job_count  = '0;
      job_words.delete();
      misses     = 0;
      due_words_o  <= 0;
      mismatches_o <= 0;
    end else begin
      // emitted job word against the oldest prediction
      if (result_valid_i) begin
        if (job_words.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("release gate: unexpected job word task %0d job %0d sensor %0d stamp %0d",
                     result_i.job_task, result_i.job_number, result_i.out_sensor,
                     result_i.out_stamp);
        end else begin
          want = job_words.pop_front();
          if (result_i.job_task !== want.job_task || result_i.job_number !== want.job_number ||
              result_i.job_prio !== want.job_prio || result_i.job_exec !== want.job_exec ||
              result_i.release_time !== want.release_time ||
              result_i.out_sensor !== want.out_sensor || result_i.out_stamp !== want.out_stamp ||
              result_i.end_of_job !== want.end_of_job) begin
            misses++;
            if (misses <= 10) begin
              $display("release gate: expected task %0d job %0d prio %0d exec %0d time %0d %s",
                       want.job_task, want.job_number, want.job_prio, want.job_exec,
                       want.release_time, "");
              $display("  sensor %0d stamp %0d last %0b", want.out_sensor, want.out_stamp,
                       want.end_of_job);
              $display("release gate: got      task %0d job %0d prio %0d exec %0d time %0d",
                       result_i.job_task, result_i.job_number, result_i.job_prio,
                       result_i.job_exec, result_i.release_time);
              $display("  sensor %0d stamp %0d last %0b", result_i.out_sensor,
                       result_i.out_stamp, result_i.end_of_job);
            end
          end
        end
      end

      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_OWN_TASK: own_id   = cfg_data_i[4:0];
          CFG_PRIORITY: prio     = cfg_data_i[7:0];
          CFG_EXEC:     exec_len = cfg_data_i[15:0];
          CFG_PERIOD:   period   = cfg_data_i;
          CFG_PARENTS:  parents  = cfg_data_i;
          CFG_SENSORS:  sensors  = cfg_data_i[3:0];
          default: ;
        endcase
      end

      // accepted item word
      if (item_start_i && !item_busy_i) begin
        // zero entries act as one, more than the table holds are cut down
        live = (sensors == 0) ? 1 : (sensors > MAX_SENSORS) ? MAX_SENSORS : int'(sensors);
        if (item_i.func == FUNC_UPDATE) begin
          if (item_i.sensor_index < live && item_i.sensor_stamp > stamps[item_i.sensor_index])
            stamps[item_i.sensor_index] = item_i.sensor_stamp;
          // done marks from tasks outside the parent set are dropped
          if (item_i.last_element && parents[item_i.source_task])
            done_marks[item_i.source_task] = 1'b1;
        end else begin
          fires = 1'b0;
          if (parents == '0 || (done_marks & parents) == parents) begin
            if (period < 0)
              fires = 1'b0;
            else if (period == 0)
              fires = 1'b1;
            else if (item_i.now_time == '0)
              fires = (parents == '0);
            else
              fires = (longint'(item_i.now_time) - longint'(last_rel)) == longint'(period);
          end
          if (fires) begin
            // a source stamps its own entry, if that entry is in use
            if (parents == '0 && own_id < live)
              stamps[own_id] = $signed({1'b0, item_i.now_time});
            for (int k = 0; k < live; k++) begin
              want.job_task     = own_id;
              want.job_number   = job_count;
              want.job_prio     = prio;
              want.job_exec     = exec_len;
              want.release_time = item_i.now_time;
              want.out_sensor   = 3'(k);
              want.out_stamp    = stamps[k];
              want.end_of_job   = (k == live - 1);
              job_words = {job_words, want};
            end
            last_rel   = item_i.now_time;
            job_count  = job_count + 32'd1;
            done_marks = '0;
          end
        end
      end

      due_words_o  <= job_words.size();
      mismatches_o <= misses;
    end
  end

endmodule

// ===== tb/sv/dag_task_release_gate_test.sv =====
`timescale 1ns / 100ps
// dag_task_release_gate_test: stimulus and verdict for the dag task release gate
// drives item and config words into dag_task_release_gate, checking sits in
// dag_task_release_gate_checker; depends on dtrg_pkg
module dag_task_release_gate_test;
  import dtrg_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         item = '0;
  logic        result_valid;
  out_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          due_words;
  int          mismatches;
  int          cycles = 0;

  // rough copy of the release timing, only used to aim tick times
  logic [31:0]        cur_mask = '0;
  logic signed [31:0] cur_period = -32'sd1;
  logic [30:0]        base_time = '0;
  logic [31:0]        marks = '0;
  bit                 calm = 1'b0;

  dag_task_release_gate DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  dag_task_release_gate_checker release_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_start_i   (start),
    .item_busy_i    (busy),
    .item_i         (item),
    .result_valid_i (result_valid),
    .result_i       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .due_words_o    (due_words),
    .mismatches_o   (mismatches)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("dag_task_release_gate_test: FAIL");
      $finish;
    end
  end

  function automatic bit tick_fires(input logic [30:0] now);
    if (cur_mask != '0 && (marks & cur_mask) != cur_mask) return 1'b0;
    if (cur_period < 0) return 1'b0;
    if (cur_period == 0) return 1'b1;
    if (now == '0) return cur_mask == '0;
    return (longint'(now) - longint'(base_time)) == longint'(cur_period);
  endfunction

  function automatic in_t update_word(input logic [4:0] src, input logic [2:0] idx,
                                      input logic signed [31:0] stamp, input logic last);
    in_t w;
    w.func         = FUNC_UPDATE;
    w.now_time     = 31'($urandom);
    w.source_task  = src;
    w.sensor_index = idx;
    w.sensor_stamp = stamp;
    w.last_element = last;
    return w;
  endfunction

  // fields other than the time are don't-care on a tick, so they are scrambled
  function automatic in_t tick_word(input logic [30:0] now);
    in_t w;
    w.func         = FUNC_TICK;
    w.now_time     = now;
    w.source_task  = 5'($urandom);
    w.sensor_index = 3'($urandom);
    w.sensor_stamp = $urandom;
    w.last_element = 1'($urandom);
    return w;
  endfunction

  function automatic logic signed [31:0] pick_stamp();
    case ($urandom_range(5))
      0: return STAMP_NONE;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom;
      3: return 32'sd0;
      default: return $signed(32'($urandom_range(0, 4095)));
    endcase
  endfunction

  // one item word; start stays high unless an idle gap follows
  task automatic send_word(input in_t w);
    start <= 1'b1;
    item  <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (w.func == FUNC_UPDATE) begin
      if (w.last_element && cur_mask[w.source_task]) marks[w.source_task] = 1'b1;
    end else if (tick_fires(w.now_time)) begin
      base_time = w.now_time;
      marks     = '0;
    end
    if (!calm && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // hold off until every predicted job word is out and the block is quiet
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_words != 0 || busy) @(posedge clk_i);
    // an update may still be in flight with nothing predicted for it
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic configure(input logic [4:0] own, input logic [7:0] prio,
                           input logic [15:0] exec_len, input logic signed [31:0] period,
                           input logic [31:0] mask, input logic [3:0] sensors);
    wait_idle();
    write_reg(CFG_OWN_TASK, 32'(own));
    write_reg(CFG_PRIORITY, 32'(prio));
    write_reg(CFG_EXEC, 32'(exec_len));
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_PARENTS, mask);
    write_reg(CFG_SENSORS, 32'(sensors));
    cfg_valid <= 1'b0;
    cur_period = period;
    cur_mask   = mask;
  endtask

  // one round: update words from every parent, then a tick aimed at a release;
  // about one round in four is flawed on purpose
  task automatic feed_job(input bit wide_time);
    int          parents [$];
    int          first, skip, reps, flaw, p, i, j, t;
    logic [30:0] now;
    longint      target;
    for (t = 0; t < 32; t++) if (cur_mask[t]) parents = {parents, t};
    flaw  = ($urandom_range(99) < 75) ? 0 : $urandom_range(1, 3);
    skip  = (flaw == 1 && parents.size() != 0) ? $urandom_range(parents.size() - 1) : -1;
    first = (parents.size() != 0) ? $urandom_range(parents.size() - 1) : 0;
    for (i = 0; i < parents.size(); i++) begin
      p    = parents[(first + i) % parents.size()];
      reps = (parents.size() > 8) ? 1 : $urandom_range(1, 3);
      for (j = 0; j < reps; j++)
        send_word(update_word(5'(p), 3'($urandom), pick_stamp(), j == reps - 1 && i != skip));
      // stray word from any task
      if ($urandom_range(9) == 0)
        send_word(update_word(5'($urandom), 3'($urandom), pick_stamp(), 1'($urandom)));
    end
    if (parents.size() == 0)
      repeat ($urandom_range(0, 2))
        send_word(update_word(5'($urandom), 3'($urandom), pick_stamp(), 1'($urandom)));
    if (cur_period > 0) begin
      target = longint'(base_time) + longint'(cur_period);
      now    = (target > 64'h7FFF_FFFF) ? '0 : 31'(target);
      if (flaw == 2) now = now + 31'd1;
    end else begin
      now = wide_time ? 31'($urandom) : 31'($urandom_range(0, 1 << 24));
    end
    if (flaw == 3) now = '0;
    send_word(tick_word(now));
    if ($urandom_range(19) == 0) wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: negative period, nothing is released
    send_word(tick_word(31'd0));
    send_word(update_word(5'd3, 3'd0, 32'sd5, 1'b1));

    // source with the largest period
    configure(5'd0, 8'd255, 16'hFFFF, 32'sh7FFF_FFFF, 32'h0, 4'd8);
    send_word(update_word(5'd31, 3'd7, 32'sh7FFF_FFFF, 1'b0));
    send_word(update_word(5'd0, 3'd2, STAMP_NONE, 1'b1));
    // most negative stamp never wins the merge
    send_word(update_word(5'd1, 3'd3, 32'sh8000_0000, 1'b0));
    // a source releases at time zero, then one full period later
    send_word(tick_word(31'd0));
    send_word(tick_word(31'h7FFF_FFFF));
    send_word(tick_word(31'd5));

    // two parents, zero sensor count acts as one
    configure(5'd31, 8'd0, 16'd0, 32'sd0, 32'h8000_0001, 4'd0);
    send_word(update_word(5'd0, 3'd0, 32'sd100, 1'b0));
    // entry beyond the count: mark counts, table untouched
    send_word(update_word(5'd0, 3'd1, 32'sd50, 1'b1));
    send_word(tick_word(31'd77));
    // done mark from a task outside the parent set
    send_word(update_word(5'd5, 3'd0, 32'sd3, 1'b1));
    send_word(update_word(5'd31, 3'd0, 32'sd7, 1'b1));
    send_word(tick_word(31'd123));

    // count above the table size
    configure(5'd7, 8'd1, 16'd2, 32'sd0, 32'h0, 4'd15);
    send_word(tick_word(31'd42));
    // own entry outside the used entries
    configure(5'd9, 8'd128, 16'h8000, 32'sd0, 32'h0, 4'd4);
    send_word(tick_word(31'd1000));

    // source releasing on every tick, with no idle gaps
    calm = 1'b1;
    configure(5'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 32'sd0, 32'h0, 4'd8);
    repeat (8) feed_job(1'b1);
    calm = 1'b0;

    // source with a short period
    configure(5'($urandom), 8'($urandom), 16'($urandom), 32'($urandom_range(1, 1000)), 32'h0,
              4'($urandom_range(1, 8)));
    repeat (7) feed_job(1'b0);

    // up to three parents, longer period, any sensor count
    configure(5'($urandom), 8'($urandom), 16'($urandom), 32'($urandom_range(1, 1 << 20)),
              (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31)) |
              (32'd1 << $urandom_range(31)), 4'($urandom));
    repeat (3) feed_job(1'b0);

    // parents released whenever triggered
    configure(5'd31, 8'($urandom), 16'($urandom), 32'sd0,
              32'h8000_0000 | (32'd1 << $urandom_range(30)), 4'd15);
    repeat (3) feed_job(1'b0);

    // every task is a parent
    configure(5'($urandom), 8'($urandom), 16'($urandom), 32'sd0, 32'hFFFF_FFFF, 4'd8);
    feed_job(1'b0);

    // negative periods never release
    configure(5'($urandom), 8'($urandom), 16'($urandom), -32'sd1,
              (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31)), 4'd3);
    repeat (2) feed_job(1'b0);
    configure(5'($urandom), 8'($urandom), 16'($urandom), 32'sh8000_0000, 32'h0, 4'd2);
    repeat (2) feed_job(1'b0);

    wait_idle();
    if (mismatches == 0)
      $display("dag_task_release_gate_test: PASS");
    else
      $display("dag_task_release_gate_test: FAIL");
    $finish;
  end

endmodule
